// ===== design/pscc_pkg.sv =====
// Constants shared by the polar speed to cosine component: angle reduction and CORDIC tables.
`default_nettype none

package pscc_pkg;

  // Width of the angle field.
  localparam int ANGLE_W = 16;

  // The angle is split as angle = 45 * q + r; the offset makes it nonnegative first.
  localparam int ANG_DIV   = 45;
  localparam int ANG_OFS   = 32805;      // 45 * 729
  localparam int ANG_QOFS  = 729;
  localparam int AOFF_W    = 17;
  localparam int RECIP45   = 93206;      // floor(2^22 / 45)
  localparam int RECIP_SH  = 22;
  localparam int PROD0_W   = 34;
  localparam int Q_W       = 12;

  // CORDIC datapath widths.
  localparam int CX_W = 34;
  localparam int CZ_W = 33;

  // Limit gain 0.6072529350 in Q30.
  localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;

  // atan(2^-i) in phase units, 2^32 per turn.
  localparam int ATAN_LEN = 24;
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

`default_nettype wire

// ===== design/polar_speed_to_cosine_component.sv =====
// Top level of the polar speed to cosine component: a pipelined CORDIC cosine times speed.
`default_nettype none

// Each beat carries an angle in 1/2^ANGLE_FRAC_BITS degree and a signed Q16.8 speed and
// yields speed * cos(angle) in Q16.8, rounded half up and saturated; a missing input gives
// a zero component flagged missing. The datapath is a fixed pipeline of CORDIC_STAGES + 5
// register stages (angle reduction in three, one per CORDIC rotation, one multiply, one
// rounding and output register), and a new beat is taken every cycle while in_ready is
// high. Stalls propagate stage by stage: in_ready stays high while any stage,
// the output register included, is empty.
module polar_speed_to_cosine_component #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int SPEED_WIDTH     = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [pscc_pkg::ANGLE_W-1:0]  in_angle,
  input  wire logic                                 in_angle_missing,
  input  wire logic signed [SPEED_WIDTH-1:0]        in_speed,
  input  wire logic                                 in_speed_missing,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SPEED_WIDTH-1:0]             out_component,
  output logic                                      out_component_missing
);

  import pscc_pkg::*;

  localparam int CS    = CORDIC_STAGES;
  localparam int SW    = SPEED_WIDTH;
  localparam int S     = CS + 5;
  localparam int ST_P  = CS + 3;
  localparam int ST_O  = CS + 4;
  localparam int PH_SH = 29 - ANGLE_FRAC_BITS;
  localparam int PW    = SW + CX_W;

  localparam logic signed [PW-1:0]   RND_HALF = PW'(64'sd536870912);
  localparam logic signed [PW-1:0]   SAT_HI   = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [PW-1:0]   SAT_LO   = PW'(-(64'sd1 <<< (SW - 1)));
  localparam logic signed [CZ_W-1:0] QTR_TURN = 33'sd1073741824;

  // Valid bits and per-stage load enables.
  logic [S-1:0] vld_r;
  logic [S-1:0] en;

  genvar k;
  generate
    for (k = 0; k < S; k++) begin : g_en
      assign en[k] = out_ready || !(&vld_r[S-1:k]);
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = vld_r[ST_O];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int j = 1; j < S; j++) begin
        if (en[j]) begin
          vld_r[j] <= vld_r[j-1];
        end
      end
    end
  end

  // Speed and missing flag travel alongside the angle.
  logic signed [SW-1:0] spd_r  [ST_P];
  logic                 miss_r [ST_O];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      miss_r[0] <= in_angle_missing | in_speed_missing;
      spd_r[0]  <= in_speed;
    end
    for (int j = 1; j < ST_O; j++) begin
      if (en[j]) begin
        miss_r[j] <= miss_r[j-1];
      end
    end
    for (int j = 1; j < ST_P; j++) begin
      if (en[j]) begin
        spd_r[j] <= spd_r[j-1];
      end
    end
  end

  // Stage 0: offset angle and reciprocal multiply for the quotient by 45.
  logic [AOFF_W:0]      aoff_s;
  logic [PROD0_W-1:0]   prod0;
  logic [AOFF_W-1:0]    s0_aoff_r;
  logic [Q_W-1:0]       s0_q0_r;

  assign aoff_s = {{(AOFF_W + 1 - ANGLE_W){in_angle[ANGLE_W-1]}}, in_angle}
                + (AOFF_W + 1)'(ANG_OFS);
  assign prod0  = PROD0_W'(aoff_s[AOFF_W-1:0]) * PROD0_W'(RECIP45);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_aoff_r <= aoff_s[AOFF_W-1:0];
      s0_q0_r   <= prod0[RECIP_SH +: Q_W];
    end
  end

  // Stage 1: remainder with one correction step.
  logic [AOFF_W:0]        rem0;
  logic                   rem_ge;
  logic signed [Q_W-1:0]  s1_qa_r;
  logic [5:0]             s1_ra_r;

  assign rem0   = (AOFF_W + 1)'(s0_aoff_r)
                - (AOFF_W + 1)'(s0_q0_r) * (AOFF_W + 1)'(ANG_DIV);
  assign rem_ge = rem0 >= (AOFF_W + 1)'(ANG_DIV);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_qa_r <= signed'(s0_q0_r + Q_W'(rem_ge) - Q_W'(ANG_QOFS));
      s1_ra_r <= rem_ge ? 6'(rem0 - (AOFF_W + 1)'(ANG_DIV)) : rem0[5:0];
    end
  end

  // Stage 2: phase from quotient and remainder, then the quadrant fold.
  logic [31:0]            frac_tab [64];
  logic signed [31:0]     qa_ext;
  logic [31:0]            phase;
  logic                   fold;
  logic signed [CZ_W-1:0] s2_z_r;
  logic                   s2_neg_r;

  generate
    for (k = 0; k < 64; k++) begin : g_frac
      assign frac_tab[k] = 32'(((64'(k) << PH_SH) + 64'd22) / 64'(ANG_DIV));
    end
  endgenerate

  assign qa_ext = 32'(s1_qa_r);
  assign phase  = 32'(qa_ext <<< PH_SH) + frac_tab[s1_ra_r];
  assign fold   = phase[31] ^ phase[30];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_z_r   <= {phase[31] ^ fold, phase[31] ^ fold, phase[30:0]};
      s2_neg_r <= fold;
    end
  end

  // CORDIC rotation stages.
  logic signed [CX_W-1:0] cx_r   [CS];
  logic signed [CX_W-1:0] cy_r   [CS];
  logic signed [CZ_W-1:0] cz_r   [CS];
  logic                   cneg_r [CS];

  generate
    for (k = 0; k < CS; k++) begin : g_cordic
      logic signed [CX_W-1:0] x_in;
      logic signed [CX_W-1:0] y_in;
      logic signed [CZ_W-1:0] z_in;
      logic                   neg_in;
      logic signed [CZ_W-1:0] atan_v;

      if (k == 0) begin : g_first
        assign x_in   = GAIN_Q30;
        assign y_in   = '0;
        assign z_in   = s2_z_r;
        assign neg_in = s2_neg_r;
      end else begin : g_rest
        assign x_in   = cx_r[k-1];
        assign y_in   = cy_r[k-1];
        assign z_in   = cz_r[k-1];
        assign neg_in = cneg_r[k-1];
      end

      assign atan_v = signed'(CZ_W'(ATAN_TAB[k]));

      always_ff @(posedge clk) begin
        if (en[3 + k]) begin
          if (!z_in[CZ_W-1]) begin
            cx_r[k] <= x_in - (y_in >>> k);
            cy_r[k] <= y_in + (x_in >>> k);
            cz_r[k] <= z_in - atan_v;
          end else begin
            cx_r[k] <= x_in + (y_in >>> k);
            cy_r[k] <= y_in - (x_in >>> k);
            cz_r[k] <= z_in + atan_v;
          end
          cneg_r[k] <= neg_in;
        end
      end
    end
  endgenerate

  // Product of speed and signed cosine.
  logic signed [CX_W-1:0] cos_v;
  logic signed [PW-1:0]   spd_x;
  logic signed [PW-1:0]   cos_x;
  logic signed [PW-1:0]   p_r;

  assign cos_v = cneg_r[CS-1] ? -cx_r[CS-1] : cx_r[CS-1];
  assign spd_x = PW'(spd_r[ST_P-1]);
  assign cos_x = PW'(cos_v);

  always_ff @(posedge clk) begin
    if (en[ST_P]) begin
      p_r <= spd_x * cos_x;
    end
  end

  // Round half up to Q16.8 and saturate.
  logic signed [PW-1:0] rnd;
  logic signed [SW-1:0] sat;

  assign rnd = (p_r + RND_HALF) >>> 30;

  always_comb begin
    priority if (rnd > SAT_HI) begin
      sat = SAT_HI[SW-1:0];
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO[SW-1:0];
    end else begin
      sat = rnd[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_O]) begin
      out_component         <= miss_r[ST_O-1] ? '0 : sat;
      out_component_missing <= miss_r[ST_O-1];
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (s1_ra_r < 6'(ANG_DIV)))
    else $error("angle remainder out of range");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> ((s2_z_r >= -QTR_TURN) && (s2_z_r < QTR_TURN)))
    else $error("folded CORDIC angle outside a half turn");

  a_ready_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> in_ready)
    else $error("input stalled while the pipeline has an empty stage");

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_component_missing) |-> (out_component == '0))
    else $error("missing result carries a nonzero component");
`endif

endmodule

`default_nettype wire
